// ----- src/tfcl_pkg.sv -----
// ----------------------------------------------------------------------------
// tfcl_pkg: shared types and constants of the transfer-function colour lookup
// Transaction structs, command and register codes, and fixed-point widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tfcl_pkg;

    // Channel width and colour word layout (red in the lowest byte).
    localparam int CHANNEL_BITS        = 8;
    localparam int NUM_CHANNELS        = 4;
    localparam int WORD_BITS           = NUM_CHANNELS * CHANNEL_BITS;
    localparam int DEFAULT_TABLE_DEPTH = 256;

    // Fixed point: the normalised position has 40 fraction bits and the
    // blend fraction is the 16 bits below the integer part.
    localparam int Q_FRAC_BITS = 40;
    localparam int F_BITS      = 16;
    localparam int F_LSB       = Q_FRAC_BITS - F_BITS;
    localparam int FRAC_ONE    = 1 << F_BITS;
    localparam int FRAC_HALF   = 1 << (F_BITS - 1);

    // Commands carried by an input transaction.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_VALUE  = 2'd0;
    localparam logic [1:0] CFG_SCALE      = 2'd1;
    localparam logic [1:0] CFG_TABLE_SIZE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] RST_MIN_VALUE  = 32'h0000_0000;
    localparam logic [31:0] RST_SCALE      = 32'h0100_0000;
    localparam logic [8:0]  RST_TABLE_SIZE = 9'd0;

    typedef struct packed {
        logic                 command;
        logic signed [31:0]   value;
        logic [7:0]           entry_index;
        logic [WORD_BITS-1:0] entry_color;
    } t_in_item;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] alpha;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic [31:0]        scale;
        logic [8:0]         table_size;
    } t_cfg;

    // Control travelling with a table request.
    typedef struct packed {
        logic load;   // transaction writes the table, no result
        logic wr_en;  // load index lies inside the table
        logic zero;   // sample gives an all-zero colour
    } t_req_ctl;

endpackage

`default_nettype wire

// ----- src/tfcl_front.sv -----
// ----------------------------------------------------------------------------
// tfcl_front: normalisation and index pipeline
// Four stages: range offset, scale products, clamping, and table position.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcl_front
    import tfcl_pkg::*;
#(
    parameter  int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    input  wire t_in_item          i_item,
    output logic                   o_ready,
    output logic                   o_valid,
    output t_req_ctl               o_ctl,
    output logic [ADDR_W-1:0]      o_addr,
    output logic [F_BITS-1:0]      o_frac,
    output logic [WORD_BITS-1:0]   o_data,
    input  wire logic              i_ready
);

    localparam int P_W = Q_FRAC_BITS + ADDR_W;

    logic ready1, ready2, ready3, ready4;
    logic r_v1, r_v2, r_v3, r_v4;

    // Stage 1: offset from the range minimum, as sign and magnitude.
    logic signed [32:0]   n1_diff;
    logic                 r1_load, r1_neg;
    logic [31:0]          r1_mag;
    logic [7:0]           r1_index;
    logic [WORD_BITS-1:0] r1_color;

    // Stage 2: the two halves of the scale product.
    logic                 r2_load, r2_neg;
    logic [47:0]          r2_hi, r2_lo;
    logic [7:0]           r2_index;
    logic [WORD_BITS-1:0] r2_color;

    // Stage 3: position clamped to the unit range and classified.
    logic [48:0]            n3_q;
    logic                   n3_sat, n3_over, n3_qnz;
    logic                   r3_load, r3_zero, r3_last;
    logic [Q_FRAC_BITS-1:0] r3_q;
    logic [7:0]             r3_index;
    logic [WORD_BITS-1:0]   r3_color;

    // Table geometry from the configuration.
    logic              tbl_empty, tbl_single;
    logic [ADDR_W-1:0] tbl_last;

    // Stage 4: table position.
    logic [P_W-1:0]       n4_p;
    logic [ADDR_W-1:0]    n4_base;
    t_req_ctl             n4_ctl, r4_ctl;
    logic [ADDR_W-1:0]    n4_addr, r4_addr;
    logic [F_BITS-1:0]    n4_frac, r4_frac;
    logic [WORD_BITS-1:0] r4_data;

    assign ready4  = !r_v4 || i_ready;
    assign ready3  = !r_v3 || ready4;
    assign ready2  = !r_v2 || ready3;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ready1) r_v1 <= i_valid;
            if (ready2) r_v2 <= r_v1;
            if (ready3) r_v3 <= r_v2;
            if (ready4) r_v4 <= r_v3;
        end
    end

    assign n1_diff = 33'(i_item.value) - 33'(i_cfg.min_value);

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r1_load  <= (i_item.command == CMD_LOAD);
            r1_neg   <= n1_diff[32];
            r1_mag   <= n1_diff[32] ? 32'(-n1_diff) : n1_diff[31:0];
            r1_index <= i_item.entry_index;
            r1_color <= i_item.entry_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r2_load  <= r1_load;
            r2_neg   <= r1_neg;
            r2_hi    <= 48'(r1_mag) * 48'(i_cfg.scale[31:16]);
            r2_lo    <= 48'(r1_mag) * 48'(i_cfg.scale[15:0]);
            r2_index <= r1_index;
            r2_color <= r1_color;
        end
    end

    always_comb begin
        if (32'(i_cfg.table_size) > 32'(TABLE_DEPTH)) begin
            tbl_last = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            tbl_last = ADDR_W'(i_cfg.table_size - 9'd1);
        end
    end
    assign tbl_empty  = (i_cfg.table_size == 9'd0);
    assign tbl_single = (tbl_last == '0);

    // A high product at or above 2^24 already exceeds the unit range.
    assign n3_sat  = |r2_hi[47:24];
    assign n3_q    = 49'({r2_hi[23:0], 16'h0000}) + 49'(r2_lo);
    assign n3_over = n3_sat || (|n3_q[48:Q_FRAC_BITS]);
    assign n3_qnz  = n3_sat || (n3_q != '0);

    always_ff @(posedge i_clk) begin
        if (ready3) begin
            r3_load  <= r2_load;
            r3_zero  <= tbl_empty || (!tbl_single && r2_neg && n3_qnz);
            r3_last  <= tbl_single || n3_over;
            r3_q     <= n3_q[Q_FRAC_BITS-1:0];
            r3_index <= r2_index;
            r3_color <= r2_color;
        end
    end

    assign n4_p    = P_W'(r3_q) * P_W'(tbl_last);
    assign n4_base = n4_p[P_W-1:Q_FRAC_BITS];

    always_comb begin
        n4_ctl.load  = r3_load;
        n4_ctl.wr_en = r3_load && (32'(r3_index) < 32'(TABLE_DEPTH));
        n4_ctl.zero  = 1'b0;
        n4_addr      = '0;
        n4_frac      = '0;
        if (r3_load) begin
            n4_addr = ADDR_W'(r3_index);
        end else if (r3_zero) begin
            n4_ctl.zero = 1'b1;
        end else if (r3_last || (n4_base >= tbl_last)) begin
            // The last entry with a zero fraction reads back unblended.
            n4_addr = tbl_last;
        end else begin
            n4_addr = n4_base;
            n4_frac = n4_p[F_LSB +: F_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready4) begin
            r4_ctl  <= n4_ctl;
            r4_addr <= n4_addr;
            r4_frac <= n4_frac;
            r4_data <= r3_color;
        end
    end

    assign o_valid = r_v4;
    assign o_ctl   = r4_ctl;
    assign o_addr  = r4_addr;
    assign o_frac  = r4_frac;
    assign o_data  = r4_data;

endmodule

`default_nettype wire

// ----- src/tfcl_table.sv -----
// ----------------------------------------------------------------------------
// tfcl_table: colour table stage
// Writes loaded entries and reads the base entry and its successor.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcl_table
    import tfcl_pkg::*;
#(
    parameter  int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire t_req_ctl             i_ctl,
    input  wire logic [ADDR_W-1:0]    i_addr,
    input  wire logic [F_BITS-1:0]    i_frac,
    input  wire logic [WORD_BITS-1:0] i_data,
    output logic                      o_ready,
    output logic                      o_valid,
    output logic                      o_zero,
    output logic [WORD_BITS-1:0]      o_a,
    output logic [WORD_BITS-1:0]      o_b,
    output logic [F_BITS-1:0]         o_frac,
    input  wire logic                 i_ready
);

    logic [WORD_BITS-1:0] mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]    b_addr;
    logic                 r_valid, r_zero;
    logic [WORD_BITS-1:0] r_a, r_b;
    logic [F_BITS-1:0]    r_frac;

    assign o_ready = !r_valid || i_ready;

    // A successor weighted by a zero fraction plays no part, so the base
    // entry is read in its place. This covers the top entry, which always
    // comes with a zero fraction, and never touches an entry outside the
    // loaded range.
    assign b_addr = (i_frac == '0) ? i_addr : ADDR_W'(i_addr + 1'b1);

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && i_ctl.load && i_ctl.wr_en) begin
            mem[i_addr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_a    <= mem[i_addr];
            r_b    <= mem[b_addr];
            r_frac <= i_frac;
            r_zero <= i_ctl.zero;
        end
    end

    // Loads end here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && !i_ctl.load;
        end
    end

    assign o_valid = r_valid;
    assign o_zero  = r_zero;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_frac  = r_frac;

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_ctl.load) |=> !r_valid)
        else $error("table load transaction produced a result");

endmodule

`default_nettype wire

// ----- src/tfcl_blend.sv -----
// ----------------------------------------------------------------------------
// tfcl_blend: channel blend and output register
// Weights the two entries by the fraction, rounds, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcl_blend
    import tfcl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_zero,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    input  wire logic [F_BITS-1:0]    i_frac,
    output logic                      o_ready,
    output logic                      o_valid,
    output t_out_item                 o_item,
    input  wire logic                 i_ready
);

    localparam int SUM_W = CHANNEL_BITS + F_BITS + 2;

    logic [F_BITS:0]         inv_frac;
    logic [CHANNEL_BITS-1:0] n_chan [NUM_CHANNELS];
    t_out_item               n_item, r_item;
    logic                    r_valid;

    assign o_ready  = !r_valid || i_ready;
    assign inv_frac = (F_BITS + 1)'(FRAC_ONE) - (F_BITS + 1)'(i_frac);

    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
        logic [CHANNEL_BITS-1:0] a, b;
        logic [SUM_W-1:0]        sum;

        assign a   = i_a[c*CHANNEL_BITS +: CHANNEL_BITS];
        assign b   = i_b[c*CHANNEL_BITS +: CHANNEL_BITS];
        assign sum = SUM_W'(a) * SUM_W'(inv_frac) + SUM_W'(b) * SUM_W'(i_frac)
                   + SUM_W'(FRAC_HALF);
        assign n_chan[c] = i_zero ? '0 : sum[F_BITS +: CHANNEL_BITS];
    end

    assign n_item.red   = n_chan[0];
    assign n_item.green = n_chan[1];
    assign n_item.blue  = n_chan[2];
    assign n_item.alpha = n_chan[3];

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_zero_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_zero) |=> (r_item == '0))
        else $error("zero-colour sample gave a non-zero result");

endmodule

`default_nettype wire

// ----- src/transfer_function_color_lookup.sv -----
// ----------------------------------------------------------------------------
// transfer_function_color_lookup: scalar to RGBA colour through a table
// Normalises a Q16.16 scalar into the loaded transfer-function table and
// blends the two neighbouring RGBA entries by the fractional position.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------
//  input    | i_valid / o_stall      | i_item  (command, value, index, colour)
//  output   | o_valid / i_stall      | o_item  (red, green, blue, alpha)
//  config   | i_cfg_we               | i_cfg_index, i_cfg_data
//
//  One transaction is accepted every cycle while o_stall is low; a sample
//  result passes through the six register stages (offset, scale products,
//  clamp, table position, table read, blend).
//  A load transaction writes its table entry in the table read stage and
//  gives no result; a sample behind it already sees the new entry.
//  Reset clears every stage valid bit and restores the configuration; the
//  colour table is not cleared and holds nothing until loaded.
//  A stall at the output fills empty stages first and reaches o_stall only
//  when every stage holds a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module transfer_function_color_lookup
    import tfcl_pkg::*;
#(
    parameter  int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input transactions.
    input  wire logic        i_valid,
    input  wire t_in_item    i_item,
    output logic             o_stall,
    // Result transactions.
    output logic             o_valid,
    output t_out_item        o_item,
    input  wire logic        i_stall,
    // Configuration writes.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // Configuration registers, read directly by every stage. The user
    // must change them only while the pipeline is empty; nothing enforces it.
    logic signed [31:0] r_min_value;
    logic [31:0]        r_scale;
    logic [8:0]         r_table_size;
    t_cfg               cfg;

    // Front pipeline to table stage.
    logic                 front_ready, front_valid;
    t_req_ctl             front_ctl;
    logic [ADDR_W-1:0]    front_addr;
    logic [F_BITS-1:0]    front_frac;
    logic [WORD_BITS-1:0] front_data;

    // Table stage to blend stage.
    logic                 tbl_ready, tbl_valid, tbl_zero;
    logic [WORD_BITS-1:0] tbl_a, tbl_b;
    logic [F_BITS-1:0]    tbl_frac;

    logic blend_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value  <= RST_MIN_VALUE;
            r_scale      <= RST_SCALE;
            r_table_size <= RST_TABLE_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_VALUE:  r_min_value  <= i_cfg_data;
                CFG_SCALE:      r_scale      <= i_cfg_data;
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data[8:0];
                default: begin
                    // Writes outside the register list are dropped.
                end
            endcase
        end
    end

    assign cfg.min_value  = r_min_value;
    assign cfg.scale      = r_scale;
    assign cfg.table_size = r_table_size;

    // Stages one to four: offset, scale, clamp and table position.
    tfcl_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_ready (front_ready),
        .o_valid (front_valid),
        .o_ctl   (front_ctl),
        .o_addr  (front_addr),
        .o_frac  (front_frac),
        .o_data  (front_data),
        .i_ready (tbl_ready)
    );

    // Stage five: table write for loads, paired read for samples.
    tfcl_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_ctl   (front_ctl),
        .i_addr  (front_addr),
        .i_frac  (front_frac),
        .i_data  (front_data),
        .o_ready (tbl_ready),
        .o_valid (tbl_valid),
        .o_zero  (tbl_zero),
        .o_a     (tbl_a),
        .o_b     (tbl_b),
        .o_frac  (tbl_frac),
        .i_ready (blend_ready)
    );

    // Stage six: blend into the output register.
    tfcl_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tbl_valid),
        .i_zero  (tbl_zero),
        .i_a     (tbl_a),
        .i_b     (tbl_b),
        .i_frac  (tbl_frac),
        .o_ready (blend_ready),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_ready (!i_stall)
    );

    assign o_stall = !front_ready;

    // The input can only be held back by a stall from the output side.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stalled without an output stall");

    // A stall on the input side means the output holds a result.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && tbl_valid))
        else $error("input stalled while the pipeline had room");

endmodule

`default_nettype wire

// ----- bench/tb_transfer_function_color_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_transfer_function_color_lookup: self-checking bench of the colour lookup
// Checks the empty table, loads the whole table, then drives directed edge
// cases and several phases of random transactions, most with random idling
// on both sides; a predictor of the table and settings checks each result.
// ----------------------------------------------------------------------------

module tb_transfer_function_color_lookup;
    import tfcl_pkg::*;

    // The run is cut off here if it has not finished by then.
    localparam int CYCLE_LIMIT = 500000;
    // Cycles allowed after the last result for load transactions still in
    // the pipeline; the block has six register stages.
    localparam int DRAIN_CYCLES = 12;
    localparam logic [31:0] MIN_SIGNED = 32'h8000_0000;
    localparam logic [31:0] MAX_SIGNED = 32'h7FFF_FFFF;
    localparam logic [31:0] SCALE_ONE  = 32'h0100_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_in_item    i_item = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_item   o_item;
    logic        i_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_MIN_VALUE;
    logic [31:0] i_cfg_data = '0;

    // Predictor state: the settings as last written and the table contents.
    logic signed [31:0] cfg_min_value = RST_MIN_VALUE;
    logic [31:0]        cfg_scale = RST_SCALE;
    logic [8:0]         cfg_table_size = RST_TABLE_SIZE;
    logic [31:0]        loaded_table [DEFAULT_TABLE_DEPTH];

    // Colours still owed by the block, oldest first.
    t_out_item expected_colours [$];
    t_out_item next_colour;

    // Idling percentages of the sender and the receiver, and a long
    // receiver hold-off: the receiver stalls until stall_held has caught up
    // with stall_hold_target.
    int idle_pct = 0;
    int stall_pct = 0;
    int stall_hold_target = 0;
    int stall_held = 0;
    int errors = 0;
    int cycle_count;

    transfer_function_color_lookup u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_item      (o_item),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Splits a table word into its channels; red sits in the lowest byte.
    function automatic t_out_item unpack_word(input logic [31:0] word);
        t_out_item colour;
        colour.red   = word[7:0];
        colour.green = word[15:8];
        colour.blue  = word[23:16];
        colour.alpha = word[31:24];
        return colour;
    endfunction

    // Works out the colour for one sample transaction. The offset from the
    // bottom of the range is exact; its magnitude times the scale gives a
    // position with 40 fraction bits, which saturates at 1.0. That position
    // times the index of the last entry gives the base entry and a 16-bit
    // blend fraction.
    function automatic t_out_item lookup_colour(input logic signed [31:0] value);
        t_out_item   colour;
        logic [8:0]  size;
        logic [63:0] last;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] norm_pos;
        logic [63:0] table_pos;
        logic [63:0] base;
        logic [63:0] frac;
        logic [63:0] mix;
        logic [31:0] lo_word;
        logic [31:0] hi_word;
        logic [31:0] blended;
        longint      diff;
        colour = '0;
        // A size beyond the table depth is clamped to the depth.
        size = (cfg_table_size > 9'(DEFAULT_TABLE_DEPTH)) ?
               9'(DEFAULT_TABLE_DEPTH) : cfg_table_size;
        // An empty table gives a zero colour.
        if (size == 0)
            return colour;
        last = 64'(size) - 64'd1;
        // A table of one entry gives that entry whatever the value.
        if (last == 0)
            return unpack_word(loaded_table[0]);
        diff = longint'(value) - longint'(cfg_min_value);
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        hi   = mag * {48'd0, cfg_scale[31:16]};
        lo   = mag * {48'd0, cfg_scale[15:0]};
        norm_pos = (hi >= (64'd1 << 24)) ? (64'd1 << Q_FRAC_BITS) : ((hi << 16) + lo);
        // Below the range the colour is zero, unless the position is zero.
        if (diff < 0 && norm_pos != 0)
            return colour;
        // At or above the top of the range the last entry is given as it is.
        if (norm_pos >= (64'd1 << Q_FRAC_BITS))
            return unpack_word(loaded_table[last[7:0]]);
        table_pos = norm_pos * last;
        base      = table_pos >> Q_FRAC_BITS;
        frac      = (table_pos >> F_LSB) & 64'(FRAC_ONE - 1);
        if (base >= last)
            return unpack_word(loaded_table[last[7:0]]);
        lo_word = loaded_table[base[7:0]];
        hi_word = loaded_table[base[7:0] + 8'd1];
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            mix = (64'(lo_word[c*CHANNEL_BITS +: CHANNEL_BITS]) * (64'(FRAC_ONE) - frac)
                 + 64'(hi_word[c*CHANNEL_BITS +: CHANNEL_BITS]) * frac
                 + 64'(FRAC_HALF)) >> F_BITS;
            blended[c*CHANNEL_BITS +: CHANNEL_BITS] = mix[CHANNEL_BITS-1:0];
        end
        return unpack_word(blended);
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Offers one transaction, after a random gap, and holds it until the
    // block takes it. Valid stays high on return so that back-to-back
    // transactions need no second assignment in the same time step. At
    // acceptance the predictor is brought up to date.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (item.command == CMD_SAMPLE)
            expected_colours.push_back(lookup_colour(item.value));
        else
            loaded_table[item.entry_index] = item.entry_color;
    endtask

    task automatic send_sample(input logic [31:0] value);
        t_in_item item;
        item.command     = CMD_SAMPLE;
        item.value       = value;
        item.entry_index = 8'($urandom);
        item.entry_color = $urandom;
        send_item(item);
    endtask

    task automatic send_load(input logic [7:0] index, input logic [31:0] colour);
        t_in_item item;
        item.command     = CMD_LOAD;
        item.value       = $urandom;
        item.entry_index = index;
        item.entry_color = colour;
        send_item(item);
    endtask

    // Stops offering and waits for every colour still owed.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_colours.size() != 0)
            @(posedge i_clk);
    endtask

    // Leaves the block idle: load transactions give no result, so a few
    // further cycles let any still in the pipeline reach the table.
    task automatic settle();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges. Only called while
    // the block is idle.
    task automatic set_config(input logic [31:0] min_value, input logic [31:0] scale,
                              input logic [8:0] size);
        logic [31:0] regs [4];
        regs[CFG_MIN_VALUE]  = min_value;
        regs[CFG_SCALE]      = scale;
        regs[CFG_TABLE_SIZE] = {23'd0, size};
        for (int r = CFG_MIN_VALUE; r <= CFG_TABLE_SIZE; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 2'(r);
            i_cfg_data  <= regs[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_min_value  = min_value;
        cfg_scale      = scale;
        cfg_table_size = size;
        @(posedge i_clk);
    endtask

    // Picks a value: mostly inside the current data range (and a little
    // past its top), some just below it, and some anywhere at all.
    function automatic logic [31:0] random_value();
        logic [63:0] span;
        logic [63:0] offset;
        logic [31:0] result;
        if (cfg_scale == 0)
            span = 64'hFFFF_FFFF;
        else
            span = (64'd1 << Q_FRAC_BITS) / 64'(cfg_scale);
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        case ($urandom_range(0, 9))
            0, 1: result = $urandom;
            2: result = cfg_min_value - $urandom_range(0, 32'h0004_0000);
            default: begin
                offset = {$urandom, $urandom} % (span + (span >> 3) + 64'd1);
                result = cfg_min_value + offset[31:0];
            end
        endcase
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // With the reset settings the table is empty, so every sample is zero
    // whatever the table holds.
    task automatic test_empty_table();
        send_sample(MIN_SIGNED);
        send_sample(MAX_SIGNED);
        send_sample(32'd0);
        settle();
    endtask

    // Writes every entry, so that no later sample can read an entry that
    // was never loaded. The first and last pairs hold the channel extremes.
    task automatic load_all_entries();
        logic [31:0] colour;
        for (int i = 0; i < DEFAULT_TABLE_DEPTH; i++) begin
            case (i)
                0, DEFAULT_TABLE_DEPTH - 2: colour = 32'h0000_0000;
                1, DEFAULT_TABLE_DEPTH - 1: colour = 32'hFFFF_FFFF;
                default: colour = $urandom;
            endcase
            send_load(8'(i), colour);
        end
        settle();
    endtask

    // A table of one entry gives entry zero for any value.
    task automatic test_single_entry();
        set_config(32'd0, SCALE_ONE, 9'd1);
        send_sample(MAX_SIGNED);
        send_sample(MIN_SIGNED);
        settle();
    endtask

    // Unit range from zero: the bottom, half way, just under and exactly at
    // 1.0, and a value just below the range. Then a two-entry table blends
    // black to white, and a load is followed at once by a sample that must
    // see the new entry.
    task automatic test_range_edges();
        set_config(32'd0, SCALE_ONE, 9'd256);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_FFFF);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_FFFF);
        settle();
        set_config(32'd0, SCALE_ONE, 9'd2);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_0001);
        send_load(8'd1, $urandom);
        send_sample(32'h0000_C000);
        settle();
    endtask

    // Extreme register values: the widest offset with the largest scale
    // and an oversized table, then a zero scale with the range starting at
    // the top, where a negative offset still lands on entry zero.
    task automatic test_extreme_settings();
        set_config(MIN_SIGNED, 32'hFFFF_FFFF, 9'd511);
        send_sample(MIN_SIGNED);
        send_sample(MIN_SIGNED + 32'd1);
        send_sample(MAX_SIGNED);
        settle();
        set_config(MAX_SIGNED, 32'd0, 9'd256);
        send_sample(MIN_SIGNED);
        send_sample(MAX_SIGNED);
        settle();
    endtask

    // Random transactions in blocks, with fresh random settings written
    // between blocks while the block is idle.
    task automatic test_random(input int total, input int sender_idle, input int receiver_stall);
        t_in_item    item;
        logic [31:0] min_value;
        logic [31:0] scale;
        logic [8:0]  size;
        int          sent;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        sent = 0;
        while (sent < total) begin
            settle();
            case ($urandom_range(0, 9))
                0: min_value = MIN_SIGNED;
                1: min_value = MAX_SIGNED;
                default: min_value = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            endcase
            case ($urandom_range(0, 9))
                0: scale = 32'd0;
                1: scale = 32'hFFFF_FFFF;
                2: scale = SCALE_ONE;
                3: scale = $urandom;
                default: scale = $urandom_range(32'h0004_0000, 32'h1000_0000);
            endcase
            case ($urandom_range(0, 9))
                0: size = 9'd0;
                1: size = 9'd1;
                2: size = 9'($urandom_range(257, 511));
                3: size = 9'd256;
                default: size = 9'($urandom_range(2, 256));
            endcase
            set_config(min_value, scale, size);
            repeat (110) begin
                item.command     = ($urandom_range(0, 99) < 20) ? CMD_LOAD : CMD_SAMPLE;
                item.value       = random_value();
                item.entry_index = 8'($urandom);
                item.entry_color = $urandom;
                send_item(item);
                sent++;
            end
        end
        settle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the pipeline fills and the input stalls. Afterwards the
    // sender pauses until every colour has come before going on.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        set_config(32'd0, SCALE_ONE, 9'd256);
        stall_hold_target = stall_hold_target + 300;
        repeat (150) send_sample(random_value());
        wait_for_results();
        repeat (40) send_sample(random_value());
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------

    // The receiver's stall: the long hold-off first, random otherwise.
    always @(posedge i_clk) begin
        if (stall_held < stall_hold_target) begin
            i_stall <= 1'b1;
            stall_held++;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic compare_channel(input string name, input logic [7:0] want,
                                   input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
            errors++;
        end
    endtask

    // Each result transaction is taken against the oldest colour owed.
    // Values read here are those sampled by the block at this same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_colours.size() == 0) begin
                $display("%0t: result transaction with none expected, expected nothing, actual %h",
                         $time, o_item);
                errors++;
            end else begin
                next_colour = expected_colours.pop_front();
                compare_channel("red",   next_colour.red,   o_item.red);
                compare_channel("green", next_colour.green, o_item.green);
                compare_channel("blue",  next_colour.blue,  o_item.blue);
                compare_channel("alpha", next_colour.alpha, o_item.alpha);
            end
        end
    end

    // Watchdog: ends the run if it has not finished within the limit.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("transfer_function_color_lookup test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        load_all_entries();
        test_single_entry();
        test_range_edges();
        test_extreme_settings();

        // Sender mostly busy with a sluggish receiver, then the reverse,
        // then both flat out.
        test_random(550, 18, 84);
        test_random(550, 84, 18);
        test_random(550, 0, 0);
        test_backpressure();

        settle();
        if (errors == 0) begin
            $display("transfer_function_color_lookup test passed");
        end else begin
            $display("transfer_function_color_lookup test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/tfcl_pkg.sv
src/tfcl_front.sv
src/tfcl_table.sv
src/tfcl_blend.sv
src/transfer_function_color_lookup.sv
bench/tb_transfer_function_color_lookup.sv
